/* design/fpcam_pkg.sv */
package fpcam_pkg;

  // command codes of the input channel
  localparam logic [1:0] CMD_KEY_DOWN = 2'd0;
  localparam logic [1:0] CMD_KEY_UP   = 2'd1;
  localparam logic [1:0] CMD_MOUSE    = 2'd2;

  // datapath micro-operations
  typedef enum logic [5:0] {
    U_NOP,
    U_UPDATE,
    U_RED_Y,
    U_RED_P,
    U_SQ,
    U_X2,
    U_M9,
    U_T7,
    U_T5,
    U_T3,
    U_T1,
    U_MT,
    U_MY,
    U_YP,
    U_YM,
    U_R0,
    U_R1,
    U_R2,
    U_R3,
    U_R4,
    U_MFX,
    U_MSX,
    U_MFY,
    U_MFZ,
    U_MSZ,
    U_LD,
    U_ADD,
    U_RND,
    U_PX,
    U_PY,
    U_PZ,
    U_TA0,
    U_TB0,
    U_TA1,
    U_TB1,
    U_TC1,
    U_TA2,
    U_TB2,
    U_TC2,
    U_TW0,
    U_TW1,
    U_TW2
  } uop_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    uop_t       uop;
    logic [1:0] row;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] cmd;
  } dp_stat_t;

endpackage

/* design/fpcam_ctrl.sv */
module fpcam_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  fpcam_pkg::dp_stat_t stat,
  output fpcam_pkg::dp_cmd_t  ctl
);
  import fpcam_pkg::*;

  typedef logic [6:0] pc_t;
  typedef enum logic [1:0] {S_IDLE, S_RUN, S_EMIT} state_t;

  localparam pc_t ROT_LAST    = 7'd55;
  localparam pc_t TRANS_START = 7'd70;
  localparam pc_t PROG_LAST   = 7'd86;

  state_t     state;
  pc_t        pc;
  logic [1:0] row;
  logic       accept;

  // one pass of the sine polynomial
  function automatic uop_t sine_step(input logic [3:0] k);
    case (k)
      4'd0:    return U_SQ;
      4'd1:    return U_X2;
      4'd2:    return U_M9;
      4'd3:    return U_T7;
      4'd4:    return U_MT;
      4'd5:    return U_T5;
      4'd6:    return U_MT;
      4'd7:    return U_T3;
      4'd8:    return U_MT;
      4'd9:    return U_T1;
      4'd10:   return U_MY;
      default: return U_NOP;
    endcase
  endfunction

  // microprogram
  function automatic uop_t prog_at(input pc_t p);
    case (p) inside
      7'd0:        return U_UPDATE;
      7'd1:        return U_RED_Y;
      [7'd2:7'd12]:  return sine_step(4'(p - 7'd2));
      7'd13:       return U_YP;
      [7'd14:7'd24]: return sine_step(4'(p - 7'd14));
      7'd25:       return U_YM;
      7'd26:       return U_RED_P;
      [7'd27:7'd37]: return sine_step(4'(p - 7'd27));
      7'd38:       return U_YP;
      [7'd39:7'd49]: return sine_step(4'(p - 7'd39));
      7'd50:       return U_YM;
      7'd51:       return U_R0;
      7'd52:       return U_R1;
      7'd53:       return U_R2;
      7'd54:       return U_R3;
      7'd55:       return U_R4;
      7'd56:       return U_MFX;
      7'd57:       return U_MSX;
      7'd58:       return U_ADD;
      7'd59:       return U_RND;
      7'd60:       return U_PX;
      7'd61:       return U_MFY;
      7'd62:       return U_LD;
      7'd63:       return U_RND;
      7'd64:       return U_PY;
      7'd65:       return U_MFZ;
      7'd66:       return U_MSZ;
      7'd67:       return U_ADD;
      7'd68:       return U_RND;
      7'd69:       return U_PZ;
      7'd70:       return U_TA0;
      7'd71:       return U_TB0;
      7'd72:       return U_ADD;
      7'd73:       return U_RND;
      7'd74:       return U_TW0;
      7'd75:       return U_TA1;
      7'd76:       return U_TB1;
      7'd77:       return U_TC1;
      7'd78:       return U_ADD;
      7'd79:       return U_RND;
      7'd80:       return U_TW1;
      7'd81:       return U_TA2;
      7'd82:       return U_TB2;
      7'd83:       return U_TC2;
      7'd84:       return U_ADD;
      7'd85:       return U_RND;
      7'd86:       return U_TW2;
      default:     return U_NOP;
    endcase
  endfunction

  // handshake and commands
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign ctl.load = accept;
  assign ctl.uop  = (state == S_RUN) ? prog_at(pc) : U_NOP;
  assign ctl.row  = row;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      row       <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_RUN;
            pc    <= '0;
          end
        end
        S_RUN: begin
          if (pc == '0) begin
            if (stat.cmd == CMD_KEY_DOWN || stat.cmd == CMD_MOUSE) begin
              pc <= 7'd1;
            end else begin
              state <= S_IDLE;
            end
          end else if (pc == ROT_LAST && stat.cmd != CMD_KEY_DOWN) begin
            pc <= TRANS_START;
          end else if (pc == PROG_LAST) begin
            state     <= S_EMIT;
            row       <= '0;
            out_valid <= 1'b1;
          end else begin
            pc <= pc + 7'd1;
          end
        end
        S_EMIT: begin
          if (!out_stall) begin
            if (row == 2'd3) begin
              out_valid <= 1'b0;
              state     <= S_IDLE;
            end else begin
              row <= row + 2'd1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/fpcam_dp.sv */
module fpcam_dp (
  input  logic                clk,
  input  logic                rst,
  input  fpcam_pkg::dp_cmd_t  ctl,
  output fpcam_pkg::dp_stat_t stat,
  input  logic [1:0]          cmd,
  input  logic [7:0]          key_code,
  input  logic signed [11:0]  mouse_dx,
  input  logic signed [11:0]  mouse_dy,
  input  logic                speed_we,
  input  logic [30:0]         speed_wdata,
  output logic [1:0]          row_index,
  output logic signed [31:0]  col0,
  output logic signed [31:0]  col1,
  output logic signed [31:0]  col2,
  output logic signed [31:0]  col3,
  output logic                last_row
);
  import fpcam_pkg::*;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [30:0] PC1     = 31'd1686629713;
  localparam logic [30:0] PC3     = 31'd693598669;
  localparam logic [30:0] PC5     = 31'd85569306;
  localparam logic [30:0] PC7     = 31'd5026995;
  localparam logic [30:0] PC9     = 31'd172272;
  localparam logic [7:0]  KEY_W   = 8'h57;
  localparam logic [7:0]  KEY_A   = 8'h41;
  localparam logic [7:0]  KEY_S   = 8'h53;
  localparam logic [7:0]  KEY_D   = 8'h44;
  localparam logic signed [12:0] FULL_TURN   = 13'sd1440;
  localparam logic signed [12:0] PITCH_LIMIT = 13'sd356;
  localparam logic [16:0] ONE_FX  = 17'd65536;

  // latched item
  logic [1:0]          cmd_r;
  logic [7:0]          key_r;
  logic signed [11:0]  dx_r;
  logic signed [11:0]  dy_r;

  // camera state
  logic [30:0]         speed;
  logic signed [31:0]  pos_x, pos_y, pos_z;
  logic [10:0]         yaw;
  logic signed [9:0]   pitch;
  logic [3:0]          held;

  // sine unit
  logic                ang_pitch;
  logic [1:0]          quad;
  logic [30:0]         xr, arg, x2, t;
  logic [16:0]         pv;

  // trig and rotation terms
  logic signed [17:0]  sy, cy, sp, cp, m10, m12, m20, m22;

  // shared multiplier and accumulator
  logic signed [32:0]  ma, mb;
  logic                mul_en;
  logic signed [63:0]  prod;
  logic signed [49:0]  acc;
  logic signed [34:0]  rnd;
  logic signed [31:0]  t0, t1, t2;

  // combinational helpers
  logic [3:0]          kbit;
  logic signed [12:0]  ysum, ywrap, psum, pclamp;
  logic signed [11:0]  pext;
  logic [10:0]         red_a;
  logic [1:0]          red_q;
  logic [8:0]          red_m;
  logic [11:0]         red_v;
  logic [22:0]         red_vp;
  logic [6:0]          red_t;
  logic [30:0]         red_x;
  logic [31:0]         ysh_r;
  logic [16:0]         yval;
  logic signed [17:0]  pos_p, neg_p, pos_m, neg_m;
  logic signed [17:0]  s_new, c_new;
  logic signed [63:0]  prod_rnd;
  logic signed [32:0]  spd, f_amt, s_amt;
  logic signed [17:0]  neg_m20, neg_m22, neg_sp;

  function automatic logic signed [32:0] sx33(input logic signed [17:0] v);
    return {{15{v[17]}}, v};
  endfunction

  function automatic logic signed [31:0] sx32(input logic signed [17:0] v);
    return {{14{v[17]}}, v};
  endfunction

  function automatic logic signed [32:0] px33(input logic signed [31:0] v);
    return {v[31], v};
  endfunction

  // round half away from zero, drop 16 fraction bits
  function automatic logic signed [63:0] round_frac(input logic signed [63:0] v);
    logic signed [63:0] b;
    b = v + 64'sd32768 - {63'd0, v[63]};
    return b >>> 16;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -36'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  assign stat.cmd = cmd_r;

  // key decode
  always_comb begin
    case (key_r)
      KEY_W:   kbit = 4'b0001;
      KEY_A:   kbit = 4'b0010;
      KEY_S:   kbit = 4'b0100;
      KEY_D:   kbit = 4'b1000;
      default: kbit = 4'b0000;
    endcase
  end

  // mouse turn: yaw wraps, pitch clamps
  always_comb begin
    ysum = $signed({2'b00, yaw}) + {dx_r[11], dx_r};
    if (ysum < -FULL_TURN) begin
      ywrap = ysum + FULL_TURN + FULL_TURN;
    end else if (ysum < 13'sd0) begin
      ywrap = ysum + FULL_TURN;
    end else if (ysum >= FULL_TURN + FULL_TURN) begin
      ywrap = ysum - FULL_TURN - FULL_TURN;
    end else if (ysum >= FULL_TURN) begin
      ywrap = ysum - FULL_TURN;
    end else begin
      ywrap = ysum;
    end
    psum = {{3{pitch[9]}}, pitch} - {dy_r[11], dy_r};
    if (psum > PITCH_LIMIT) begin
      pclamp = PITCH_LIMIT;
    end else if (psum < -PITCH_LIMIT) begin
      pclamp = -PITCH_LIMIT;
    end else begin
      pclamp = psum;
    end
  end

  // angle reduction to quadrant and q30 fraction
  always_comb begin
    pext = {{2{pitch[9]}}, pitch};
    if (ctl.uop == U_RED_P) begin
      red_a = pitch[9] ? 11'(pext + 12'sd1440) : 11'(pext);
    end else begin
      red_a = yaw;
    end
    if (red_a >= 11'd1080) begin
      red_q = 2'd3;
      red_m = 9'(red_a - 11'd1080);
    end else if (red_a >= 11'd720) begin
      red_q = 2'd2;
      red_m = 9'(red_a - 11'd720);
    end else if (red_a >= 11'd360) begin
      red_q = 2'd1;
      red_m = 9'(red_a - 11'd360);
    end else begin
      red_q = 2'd0;
      red_m = red_a[8:0];
    end
    red_v  = {red_m, 3'b000};
    red_vp = 23'(red_v) * 23'd1457;
    red_t  = red_vp[22:16];
    if (13'(red_t) * 13'd45 > 13'(red_v)) begin
      red_t = red_t - 7'd1;
    end
    red_x = 31'(red_m) * 31'd2982616 + 31'(red_t);
  end

  // sine rounding and quadrant mapping
  always_comb begin
    ysh_r = (32'(prod[60:30]) + 32'd8192) >> 14;
    yval  = (ysh_r > 32'(ONE_FX)) ? ONE_FX : ysh_r[16:0];
    pos_p = $signed({1'b0, pv});
    neg_p = -pos_p;
    pos_m = $signed({1'b0, yval});
    neg_m = -pos_m;
    case (quad)
      2'd0:    begin s_new = pos_p; c_new = pos_m; end
      2'd1:    begin s_new = pos_m; c_new = neg_p; end
      2'd2:    begin s_new = neg_p; c_new = neg_m; end
      default: begin s_new = neg_m; c_new = pos_p; end
    endcase
    prod_rnd = round_frac(prod);
  end

  // movement amounts from held keys
  always_comb begin
    spd     = $signed({2'b00, speed});
    f_amt   = (held[0] ? spd : 33'sd0) - (held[2] ? spd : 33'sd0);
    s_amt   = (held[3] ? spd : 33'sd0) - (held[1] ? spd : 33'sd0);
    neg_m20 = -m20;
    neg_m22 = -m22;
    neg_sp  = -sp;
  end

  // multiplier operand select
  always_comb begin
    mul_en = 1'b1;
    ma     = '0;
    mb     = '0;
    case (ctl.uop)
      U_SQ:  begin ma = $signed({2'b00, arg}); mb = $signed({2'b00, arg}); end
      U_M9:  begin ma = $signed({2'b00, x2});  mb = $signed({2'b00, PC9}); end
      U_MT:  begin ma = $signed({2'b00, x2});  mb = $signed({2'b00, t});   end
      U_MY:  begin ma = $signed({2'b00, arg}); mb = $signed({2'b00, t});   end
      U_R0:  begin ma = sx33(sy);  mb = sx33(sp);  end
      U_R1:  begin ma = sx33(cy);  mb = sx33(sp);  end
      U_R2:  begin ma = sx33(cp);  mb = sx33(sy);  end
      U_R3:  begin ma = sx33(cp);  mb = sx33(cy);  end
      U_MFX: begin ma = f_amt;     mb = sx33(neg_m20); end
      U_MSX: begin ma = s_amt;     mb = sx33(cy);  end
      U_MFY: begin ma = f_amt;     mb = sx33(sp);  end
      U_MFZ: begin ma = f_amt;     mb = sx33(neg_m22); end
      U_MSZ: begin ma = s_amt;     mb = sx33(sy);  end
      U_TA0: begin ma = sx33(cy);  mb = px33(pos_x); end
      U_TB0: begin ma = sx33(sy);  mb = px33(pos_z); end
      U_TA1: begin ma = sx33(m10); mb = px33(pos_x); end
      U_TB1: begin ma = sx33(cp);  mb = px33(pos_y); end
      U_TC1: begin ma = sx33(m12); mb = px33(pos_z); end
      U_TA2: begin ma = sx33(m20); mb = px33(pos_x); end
      U_TB2: begin ma = sx33(neg_sp); mb = px33(pos_y); end
      U_TC2: begin ma = sx33(m22); mb = px33(pos_z); end
      default: mul_en = 1'b0;
    endcase
  end

  // product register
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= ma * mb;
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= cmd;
      key_r <= key_code;
      dx_r  <= mouse_dx;
      dy_r  <= mouse_dy;
    end
  end

  // speed register
  always_ff @(posedge clk) begin
    if (rst) begin
      speed <= 31'd65536;
    end else if (speed_we) begin
      speed <= speed_wdata;
    end
  end

  // camera state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      held  <= '0;
      yaw   <= '0;
      pitch <= '0;
      pos_x <= '0;
      pos_y <= '0;
      pos_z <= '0;
    end else begin
      case (ctl.uop)
        U_UPDATE: begin
          case (cmd_r)
            CMD_KEY_DOWN: held <= held | kbit;
            CMD_KEY_UP:   held <= held & ~kbit;
            CMD_MOUSE: begin
              yaw   <= 11'(ywrap);
              pitch <= 10'(pclamp);
            end
            default: ;
          endcase
        end
        U_PX: pos_x <= sat32({{4{pos_x[31]}}, pos_x} + {rnd[34], rnd});
        U_PY: pos_y <= sat32({{4{pos_y[31]}}, pos_y} + {rnd[34], rnd});
        U_PZ: pos_z <= sat32({{4{pos_z[31]}}, pos_z} + {rnd[34], rnd});
        default: ;
      endcase
    end
  end

  // sine evaluation, rotation terms, accumulate and round
  always_ff @(posedge clk) begin
    case (ctl.uop)
      U_RED_Y, U_RED_P: begin
        ang_pitch <= (ctl.uop == U_RED_P);
        quad      <= red_q;
        xr        <= red_x;
        arg       <= red_x;
      end
      U_X2: x2 <= prod[60:30];
      U_T7: t  <= PC7 - prod[60:30];
      U_T5: t  <= PC5 - prod[60:30];
      U_T3: t  <= PC3 - prod[60:30];
      U_T1: t  <= PC1 - prod[60:30];
      U_YP: begin
        pv  <= yval;
        arg <= ONE_Q30 - xr;
      end
      U_YM: begin
        if (ang_pitch) begin
          sp <= s_new;
          cp <= c_new;
        end else begin
          sy <= s_new;
          cy <= c_new;
        end
      end
      U_R1: m10 <= -prod_rnd[17:0];
      U_R2: m12 <= prod_rnd[17:0];
      U_R3: m20 <= -prod_rnd[17:0];
      U_R4: m22 <= prod_rnd[17:0];
      U_MSX, U_MSZ, U_LD, U_TB0, U_TB1, U_TB2: acc <= prod[49:0];
      U_ADD, U_TC1, U_TC2: acc <= acc + prod[49:0];
      U_RND: rnd <= 35'(round_frac({{14{acc[49]}}, acc}));
      U_TW0: t0 <= sat32(-{rnd[34], rnd});
      U_TW1: t1 <= sat32(-{rnd[34], rnd});
      U_TW2: t2 <= sat32(-{rnd[34], rnd});
      default: ;
    endcase
  end

  // result row select
  always_comb begin
    row_index = ctl.row;
    last_row  = (ctl.row == 2'd3);
    case (ctl.row)
      2'd0: begin
        col0 = sx32(cy);  col1 = '0;         col2 = sx32(sy);  col3 = t0;
      end
      2'd1: begin
        col0 = sx32(m10); col1 = sx32(cp);   col2 = sx32(m12); col3 = t1;
      end
      2'd2: begin
        col0 = sx32(m20); col1 = sx32(neg_sp); col2 = sx32(m22); col3 = t2;
      end
      default: begin
        col0 = '0; col1 = '0; col2 = '0; col3 = 32'(ONE_FX);
      end
    endcase
  end

endmodule

/* design/first_person_camera_view.sv */
// first-person camera: turns key and mouse events into a 4x4 view matrix
// input channel: cmd (key down, key up, mouse move), key_code, mouse_dx,
//   mouse_dy; a beat is taken when in_valid is high and in_stall is low
// config channel: cfg_data sets the move speed (unsigned Q15.16); cfg_ready is
//   always high, write only while no event is in flight
// output channel: four beats per key-down or mouse event, rows 0 to 3 of
//   [R | -R*pos] in Q16.16, last_row marks row 3; key up gives no beat
// datapath: one shared 33x33 multiplier runs a fixed microprogram; after
//   the last step, rows follow one per cycle while out_stall is low
// one event at a time: no new beat is taken until the current event is done
// in_stall is high after an accepted beat until the last row is taken
// reset (rst, synchronous): position, yaw, pitch and held keys cleared,
//   move speed back to one unit, no output pending
// out_stall holds the current row stable and delays the next event
module first_person_camera_view (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic [7:0]         key_code,
  input  logic signed [11:0] mouse_dx,
  input  logic signed [11:0] mouse_dy,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [30:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         row_index,
  output logic signed [31:0] col0,
  output logic signed [31:0] col1,
  output logic signed [31:0] col2,
  output logic signed [31:0] col3,
  output logic               last_row
);
  import fpcam_pkg::*;

  dp_cmd_t  ctl;
  dp_stat_t stat;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  fpcam_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  fpcam_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .stat        (stat),
    .cmd         (cmd),
    .key_code    (key_code),
    .mouse_dx    (mouse_dx),
    .mouse_dy    (mouse_dy),
    .speed_we    (cfg_valid),
    .speed_wdata (cfg_data),
    .row_index   (row_index),
    .col0        (col0),
    .col1        (col1),
    .col2        (col2),
    .col3        (col3),
    .last_row    (last_row)
  );

endmodule
